// ===== rtl/core/sensor_command_framer_checker_top_macros.svh =====
// ----------------------------------------------------------------------------
// Sensor command framer/checker assertion macros
// Concurrent assertion helpers used by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef SENSOR_COMMAND_FRAMER_CHECKER_TOP_MACROS_SVH
`define SENSOR_COMMAND_FRAMER_CHECKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define SCF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define SCF_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SCF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCF_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/scf_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor command framer/checker package
// Word types, command codes and status codes shared by the block.
// ----------------------------------------------------------------------------
package scf_pkg;

	localparam int FRAME_LEN = 9;
	localparam int NUM_CMDS  = 13;

	localparam logic FUNC_SEND = 1'b0;
	localparam logic FUNC_RECV = 1'b1;

	localparam logic KIND_TX      = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
	localparam logic [1:0] STATUS_HEADER   = 2'd2;

	localparam logic [3:0] CMD_SELF_CAL = 4'd1;
	localparam logic [3:0] CMD_ZERO_CAL = 4'd5;
	localparam logic [3:0] CMD_SPAN     = 4'd6;
	localparam logic [3:0] CMD_RANGE    = 4'd7;
	localparam logic [3:0] CMD_LAST     = 4'(NUM_CMDS - 1);

	localparam logic [7:0] HDR_START  = 8'hFF;
	localparam logic [7:0] HDR_SENSOR = 8'h01;

	typedef struct packed {
		logic        func;
		logic [3:0]  command_index;
		logic [15:0] command_data;
		logic [7:0]  rx_byte;
	} in_t;

	typedef struct packed {
		logic        out_kind;
		logic [7:0]  tx_byte;
		logic        last_of_frame;
		logic [1:0]  status;
		logic [15:0] reply_word_a;
		logic [15:0] reply_word_b;
		logic [7:0]  reply_byte_six;
		logic [7:0]  reply_byte_seven;
	} out_t;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

	// Control from the top level to the reply checker.
	typedef struct packed {
		logic       rx_en;
		logic       restart;
		logic [7:0] code;
	} chk_ctl_t;

	function automatic logic [7:0] cmd_code(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'd120;
			4'd1:    c = 8'd121;
			4'd2:    c = 8'd132;
			4'd3:    c = 8'd133;
			4'd4:    c = 8'd134;
			4'd5:    c = 8'd135;
			4'd6:    c = 8'd136;
			4'd7:    c = 8'd153;
			4'd8:    c = 8'd155;
			4'd9:    c = 8'd156;
			4'd10:   c = 8'd160;
			4'd11:   c = 8'd162;
			4'd12:   c = 8'd163;
			default: c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/sensor_command_framer_checker_top.sv =====
// ----------------------------------------------------------------------------
// Sensor command framer/checker top level
// Builds nine-byte command frames and checks nine-byte sensor replies.
// ----------------------------------------------------------------------------
// Only the ninth byte of a reply produces an output word, the verdict.
// A send word produces nine output words and holds the input for nine
// output beats: the frame sits in one stage register and shifts out one
// byte per beat into the output register, and the next input word is taken
// in the cycle its last byte moves on. With the output always ready the
// block therefore takes one receive word per cycle while no frame is going
// out. Command indexes 13 to 15 are taken and dropped without effect.
// Write abc_repeat_mode only while the block is idle.
`include "sensor_command_framer_checker_top_macros.svh"

module sensor_command_framer_checker_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  scf_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output scf_pkg::out_t out_data
);
	import scf_pkg::*;

	logic       abc_repeat_mode_q;
	logic       in_accept;
	logic       is_send;
	logic       cmd_ok;
	logic       load_s1;
	logic       chk_done;
	frame_t     frame;
	out_t       verdict;
	chk_ctl_t   chk_ctl;

	logic       busy_s1;
	logic       kind_s1;
	logic [3:0] beat_s1;
	frame_t     frame_s1;
	out_t       verdict_s1;

	logic       move;
	logic       last_beat;
	out_t       beat;
	logic       out_valid_q;
	out_t       out_q;

	assign is_send   = (in_data.func == FUNC_SEND);
	assign cmd_ok    = (in_data.command_index <= CMD_LAST);
	assign in_accept = in_valid && in_ready;

	always_comb begin
		chk_ctl.rx_en   = in_accept && !is_send;
		chk_ctl.restart = in_accept && is_send && cmd_ok;
		chk_ctl.code    = frame[2];
	end

	scf_frame_bld u_bld (
		.command_index   (in_data.command_index),
		.command_data    (in_data.command_data),
		.abc_repeat_mode (abc_repeat_mode_q),
		.frame           (frame)
	);

	scf_reply_chk u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (chk_ctl),
		.rx_byte (in_data.rx_byte),
		.done    (chk_done),
		.verdict (verdict)
	);

	assign load_s1   = chk_ctl.restart || (chk_ctl.rx_en && chk_done);
	assign move      = busy_s1 && (!out_valid_q || out_ready);
	assign last_beat = (kind_s1 == KIND_VERDICT) || (beat_s1 == 4'(FRAME_LEN - 1));
	assign in_ready  = !busy_s1 || (move && last_beat);

	always_comb begin
		if (kind_s1 == KIND_VERDICT) begin
			beat = verdict_s1;
		end else begin
			beat               = '0;
			beat.out_kind      = KIND_TX;
			beat.tx_byte       = frame_s1[0];
			beat.last_of_frame = (beat_s1 == 4'(FRAME_LEN - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abc_repeat_mode_q <= 1'b0;
			busy_s1           <= 1'b0;
			beat_s1           <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				abc_repeat_mode_q <= cfg_wdata;
			end
			if (load_s1) begin
				busy_s1 <= 1'b1;
				beat_s1 <= '0;
			end else if (move) begin
				if (last_beat) begin
					busy_s1 <= 1'b0;
				end
				beat_s1 <= 4'(beat_s1 + 4'd1);
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			kind_s1    <= is_send ? KIND_TX : KIND_VERDICT;
			frame_s1   <= frame;
			verdict_s1 <= verdict;
		end else if (move) begin
			frame_s1 <= {8'h00, frame_s1[FRAME_LEN-1:1]};
		end
		if (move) begin
			out_q <= beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Every frame opens with the start byte.
	`SCF_ASSERT(a_frame_start, clk, arst_n,
		(move && kind_s1 == KIND_TX && beat_s1 == 4'd0) |=> (out_data.tx_byte == HDR_START),
		"frame did not open with the start byte")
	// The frame marker only appears on transmit words.
	`SCF_NEVER(a_last_kind, clk, arst_n,
		out_valid && out_data.last_of_frame && out_data.out_kind != KIND_TX,
		"frame marker on a verdict word")
	// An accepted command starts a fresh frame at its first beat.
	`SCF_ASSERT(a_send_loads, clk, arst_n,
		chk_ctl.restart |=> (busy_s1 && beat_s1 == 4'd0 && kind_s1 == KIND_TX),
		"accepted command did not load a frame")

endmodule

// ===== rtl/core/scf_frame_bld.sv =====
// ----------------------------------------------------------------------------
// Command frame builder
// Places header, code and argument bytes and appends the checksum.
// ----------------------------------------------------------------------------
module scf_frame_bld (
	input  logic [3:0]    command_index,
	input  logic [15:0]   command_data,
	input  logic          abc_repeat_mode,
	output scf_pkg::frame_t frame
);
	import scf_pkg::*;

	logic [7:0] hi;
	logic [7:0] lo;
	logic [7:0] sum;

	assign hi = command_data[15:8];
	assign lo = command_data[7:0];

	always_comb begin
		frame    = '0;
		frame[0] = HDR_START;
		frame[1] = HDR_SENSOR;
		frame[2] = cmd_code(command_index);
		case (command_index)
			CMD_SELF_CAL: begin
				if (!abc_repeat_mode) begin
					frame[3] = lo;
				end
			end
			CMD_ZERO_CAL: begin
				frame[6] = lo;
			end
			CMD_SPAN: begin
				frame[3] = hi;
				frame[4] = lo;
			end
			CMD_RANGE: begin
				frame[6] = hi;
				frame[7] = lo;
			end
			default: begin
			end
		endcase
		sum = '0;
		for (int i = 1; i < FRAME_LEN - 1; i++) begin
			sum = 8'(sum + frame[i]);
		end
		frame[FRAME_LEN-1] = 8'(8'd0 - sum);
	end

endmodule

// ===== rtl/core/scf_reply_chk.sv =====
// ----------------------------------------------------------------------------
// Reply checker
// Collects reply bytes and forms the verdict word on the ninth byte.
// ----------------------------------------------------------------------------
module scf_reply_chk (
	input  logic              clk,
	input  logic              arst_n,
	input  scf_pkg::chk_ctl_t ctl,
	input  logic [7:0]        rx_byte,
	output logic              done,
	output scf_pkg::out_t     verdict
);
	import scf_pkg::*;

	logic [7:0] sent_code_q;
	logic [3:0] rx_count_q;
	logic [7:0] rx_sum_q;
	logic [7:0] rx_bytes_q [FRAME_LEN-1];
	logic [3:0] pos;
	logic       hdr_bad;
	logic       sum_bad;

	// A count past the frame length restarts collection at the first byte.
	assign pos  = (rx_count_q >= 4'(FRAME_LEN)) ? 4'd0 : rx_count_q;
	assign done = (pos == 4'(FRAME_LEN - 1));

	// The byte that closes the frame is the checksum and is compared directly.
	assign sum_bad = (rx_byte != 8'(8'd0 - rx_sum_q));
	assign hdr_bad = (rx_bytes_q[0] != HDR_START) || (rx_bytes_q[1] != sent_code_q);

	always_comb begin
		verdict                  = '0;
		verdict.out_kind         = KIND_VERDICT;
		verdict.status           = hdr_bad ? STATUS_HEADER :
		                           (sum_bad ? STATUS_CHECKSUM : STATUS_OK);
		verdict.reply_word_a     = {rx_bytes_q[2], rx_bytes_q[3]};
		verdict.reply_word_b     = {rx_bytes_q[4], rx_bytes_q[5]};
		verdict.reply_byte_six   = rx_bytes_q[6];
		verdict.reply_byte_seven = rx_bytes_q[7];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_code_q <= '0;
			rx_count_q  <= '0;
			rx_sum_q    <= '0;
		end else if (ctl.restart) begin
			sent_code_q <= ctl.code;
			rx_count_q  <= '0;
			rx_sum_q    <= '0;
		end else if (ctl.rx_en) begin
			if (done) begin
				rx_count_q <= '0;
				rx_sum_q   <= '0;
			end else begin
				rx_count_q <= 4'(pos + 4'd1);
				if (pos != 4'd0) begin
					rx_sum_q <= 8'(rx_sum_q + rx_byte);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rx_en && !ctl.restart && !done) begin
			rx_bytes_q[pos[2:0]] <= rx_byte;
		end
	end

endmodule

// ===== tb/sv/sensor_command_framer_checker_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor command framer/checker testbench
// Sends command words and reply bytes under random handshake gaps. A local
// copy of the framing and reply checking rules predicts every output word,
// and each one is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module sensor_command_framer_checker_top_tb;

	import scf_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 80;
	localparam int SHOW_LIMIT = 10;

	localparam logic [0:NUM_CMDS-1][7:0] CMD_CODES = {
		8'd120, 8'd121, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136,
		8'd153, 8'd155, 8'd156, 8'd160, 8'd162, 8'd163
	};

	typedef struct packed {
		in_t  word;
		logic typed;
		out_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// Predictor state, updated as each word is accepted.
	logic       abc_repeat;
	logic [7:0] last_code;
	logic [3:0] reply_count;
	logic [7:0] reply_sum;
	logic [7:0] reply_bytes [FRAME_LEN];

	out_t awaited_words [$];
	out_t want_word;
	stim_row_t directed_rows [$];

	bit calm;
	bit hold_req;
	int failures;
	int cycle_count;
	int frames_built;
	int dropped_cmds;
	int verdict_tally [3];

	sensor_command_framer_checker_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic in_t make_word(logic f, logic [3:0] idx, logic [15:0] d,
			logic [7:0] b);
		in_t w;
		w.func = f;
		w.command_index = idx;
		w.command_data = d;
		w.rx_byte = b;
		return w;
	endfunction

	function automatic stim_row_t cmd_row(logic [3:0] idx, logic [15:0] d);
		stim_row_t r;
		r.word = make_word(FUNC_SEND, idx, d, 8'($urandom));
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t reply_row(logic [7:0] b);
		stim_row_t r;
		r.word = make_word(FUNC_RECV, 4'($urandom), 16'($urandom), b);
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic logic [15:0] pick_data();
		logic [15:0] d;
		case ($urandom_range(0, 7))
			0:       d = 16'h0000;
			1:       d = 16'hFFFF;
			default: d = 16'($urandom);
		endcase
		return d;
	endfunction

	function automatic string show_word(out_t w);
		return $sformatf("kind=%0d tx=%02h last=%0d st=%0d a=%04h b=%04h six=%02h seven=%02h",
			w.out_kind, w.tx_byte, w.last_of_frame, w.status, w.reply_word_a,
			w.reply_word_b, w.reply_byte_six, w.reply_byte_seven);
	endfunction

	task automatic predict_framer_words(input in_t w);
		logic [7:0] frame [FRAME_LEN];
		logic [7:0] sum;
		int pos;
		out_t o;
		if (w.func == FUNC_SEND) begin
			if (w.command_index > CMD_LAST) begin
				dropped_cmds++;
				return;
			end
			foreach (frame[i]) frame[i] = 8'h00;
			frame[0] = HDR_START;
			frame[1] = HDR_SENSOR;
			frame[2] = CMD_CODES[w.command_index];
			case (w.command_index)
				CMD_SELF_CAL: if (!abc_repeat) frame[3] = w.command_data[7:0];
				CMD_ZERO_CAL: frame[6] = w.command_data[7:0];
				CMD_SPAN: begin
					frame[3] = w.command_data[15:8];
					frame[4] = w.command_data[7:0];
				end
				CMD_RANGE: begin
					frame[6] = w.command_data[15:8];
					frame[7] = w.command_data[7:0];
				end
				default: ;
			endcase
			sum = 8'h00;
			for (int i = 1; i < FRAME_LEN - 1; i++) sum = sum + frame[i];
			frame[FRAME_LEN-1] = -sum;
			last_code = frame[2];
			reply_count = '0;
			reply_sum = '0;
			for (int i = 0; i < FRAME_LEN; i++) begin
				o = '0;
				o.out_kind = KIND_TX;
				o.tx_byte = frame[i];
				o.last_of_frame = (i == FRAME_LEN - 1);
				awaited_words.push_back(o);
			end
			frames_built++;
		end else begin
			pos = reply_count;
			reply_bytes[pos] = w.rx_byte;
			if (pos >= 1 && pos <= FRAME_LEN - 2) reply_sum = reply_sum + w.rx_byte;
			if (pos < FRAME_LEN - 1) begin
				reply_count = 4'(pos + 1);
				return;
			end
			o = '0;
			o.out_kind = KIND_VERDICT;
			o.status = STATUS_OK;
			if (reply_bytes[8] != 8'(-reply_sum)) o.status = STATUS_CHECKSUM;
			// A bad header wins over a bad checksum.
			if (reply_bytes[0] != HDR_START || reply_bytes[1] != last_code)
				o.status = STATUS_HEADER;
			o.reply_word_a = {reply_bytes[2], reply_bytes[3]};
			o.reply_word_b = {reply_bytes[4], reply_bytes[5]};
			o.reply_byte_six = reply_bytes[6];
			o.reply_byte_seven = reply_bytes[7];
			awaited_words.push_back(o);
			verdict_tally[o.status]++;
			reply_count = '0;
			reply_sum = '0;
		end
	endtask

	task automatic push_word(input in_t w);
		if (!calm && $urandom_range(0, 99) < 31) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		predict_framer_words(w);
	endtask

	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_repeat_mode(input logic v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		abc_repeat = v;
	endtask

	// Mostly command frames and well-formed replies to them, with some
	// corrupted replies and stray bytes that knock the reply count off.
	task automatic run_random_traffic(input int target);
		logic [7:0] b [FRAME_LEN];
		logic [7:0] sum;
		logic [3:0] idx;
		int done;
		int pick;
		done = 0;
		while (done < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				if ($urandom_range(0, 19) == 0) idx = 4'($urandom_range(13, 15));
				else idx = 4'($urandom_range(0, 12));
				push_word(make_word(FUNC_SEND, idx, pick_data(), 8'($urandom)));
				if (idx <= CMD_LAST) done++;
			end else if (pick < 85) begin
				b[0] = ($urandom_range(0, 99) < 90) ? HDR_START : 8'($urandom);
				b[1] = ($urandom_range(0, 99) < 85) ? last_code : 8'($urandom);
				sum = b[1];
				for (int j = 2; j < FRAME_LEN - 1; j++) begin
					b[j] = 8'($urandom);
					sum = sum + b[j];
				end
				b[8] = ($urandom_range(0, 99) < 75) ? -sum : 8'($urandom);
				for (int j = 0; j < FRAME_LEN; j++)
					push_word(make_word(FUNC_RECV, 4'($urandom), 16'($urandom), b[j]));
				done += FRAME_LEN;
			end else begin
				repeat ($urandom_range(1, 5)) begin
					push_word(make_word(FUNC_RECV, 4'($urandom), 16'($urandom),
						8'($urandom)));
					done++;
				end
			end
		end
	endtask

	// Receiver: random back-pressure, always ready when calm, or a long hold-off when requested.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 31);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_words.size() == 0) begin
				failures++;
				if (failures <= SHOW_LIMIT)
					$display("unexpected output word: %s", show_word(out_data));
			end else begin
				want_word = awaited_words.pop_front();
				if (out_data.out_kind !== want_word.out_kind ||
						out_data.tx_byte !== want_word.tx_byte ||
						out_data.last_of_frame !== want_word.last_of_frame ||
						out_data.status !== want_word.status ||
						out_data.reply_word_a !== want_word.reply_word_a ||
						out_data.reply_word_b !== want_word.reply_word_b ||
						out_data.reply_byte_six !== want_word.reply_byte_six ||
						out_data.reply_byte_seven !== want_word.reply_byte_seven) begin
					failures++;
					if (failures <= SHOW_LIMIT) begin
						$display("mismatch expected: %s", show_word(want_word));
						$display("mismatch actual:   %s", show_word(out_data));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, awaited_words.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		stim_row_t r;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		abc_repeat = 1'b0;
		last_code = '0;
		reply_count = '0;
		reply_sum = '0;
		foreach (reply_bytes[i]) reply_bytes[i] = 8'h00;

		// A reply before any command is checked against a code of zero.
		directed_rows.push_back(reply_row(8'hFF));
		directed_rows.push_back(reply_row(8'h00));
		directed_rows.push_back(reply_row(8'h12));
		directed_rows.push_back(reply_row(8'h34));
		directed_rows.push_back(reply_row(8'h56));
		directed_rows.push_back(reply_row(8'h78));
		directed_rows.push_back(reply_row(8'h9A));
		directed_rows.push_back(reply_row(8'hBC));
		r = reply_row(8'h96);
		r.typed = 1'b1;
		r.want = '{KIND_VERDICT, 8'h00, 1'b0, STATUS_OK, 16'h1234, 16'h5678, 8'h9A, 8'hBC};
		directed_rows.push_back(r);
		r = cmd_row(4'd0, 16'hFFFF);
		r.typed = 1'b1;
		r.want = '{KIND_TX, 8'h87, 1'b1, STATUS_OK, 16'h0000, 16'h0000, 8'h00, 8'h00};
		directed_rows.push_back(r);
		directed_rows.push_back(cmd_row(CMD_SELF_CAL, 16'hFFFF));
		directed_rows.push_back(cmd_row(CMD_ZERO_CAL, 16'h00FF));
		directed_rows.push_back(cmd_row(CMD_SPAN, 16'hFFFF));
		directed_rows.push_back(cmd_row(CMD_RANGE, 16'h0000));
		directed_rows.push_back(cmd_row(CMD_LAST, 16'hFFFF));
		// Indexes past the last command are dropped.
		directed_rows.push_back(cmd_row(4'd13, 16'hFFFF));
		directed_rows.push_back(cmd_row(4'd15, 16'h0000));
		// A command in the middle of a reply restarts reply collection.
		directed_rows.push_back(reply_row(8'hFF));
		directed_rows.push_back(reply_row(8'hA3));
		directed_rows.push_back(reply_row(8'h55));
		directed_rows.push_back(cmd_row(CMD_SPAN, 16'h8001));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_repeat_mode(1'b0);
		foreach (directed_rows[i]) begin
			push_word(directed_rows[i].word);
			if (directed_rows[i].typed)
				awaited_words[awaited_words.size() - 1] = directed_rows[i].want;
		end
		wait_for_quiet();

		// Hold the output off while commands keep coming so the block backs up.
		write_repeat_mode(1'b1);
		hold_req = 1'b1;
		calm = 1'b1;
		repeat (6)
			push_word(make_word(FUNC_SEND, 4'($urandom_range(0, 12)), pick_data(),
				8'($urandom)));
		calm = 1'b0;
		run_random_traffic(25);
		wait_for_quiet();

		write_repeat_mode(1'b0);
		calm = 1'b1;
		run_random_traffic(25);
		calm = 1'b0;
		wait_for_quiet();

		write_repeat_mode(1'b1);
		run_random_traffic(25);
		wait_for_quiet();

		$display("covered %0d command frames and %0d dropped commands",
			frames_built, dropped_cmds);
		$display("reply verdicts: %0d ok, %0d checksum error, %0d header mismatch",
			verdict_tally[STATUS_OK], verdict_tally[STATUS_CHECKSUM],
			verdict_tally[STATUS_HEADER]);
		if (failures == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d failures", failures);
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/scf_pkg.sv
rtl/core/scf_frame_bld.sv
rtl/core/scf_reply_chk.sv
rtl/core/sensor_command_framer_checker_top.sv
tb/sv/sensor_command_framer_checker_top_tb.sv
